// File: design/itl_pkg.sv
// Shared types and constants for the IPv6 multibit trie lookup block.
// No dependencies; every module of the block imports this package.
package itl_pkg;

    // Address bytes walked per lookup, one trie level each
    localparam int ADDR_BYTES = 16;
    localparam int DEPTH_W    = $clog2(ADDR_BYTES + 1);
    localparam int ADDR_W     = 8 * ADDR_BYTES;
    // Widest entry-store address: 8-bit node index and 8-bit byte slot
    localparam int MEM_AW_MAX = 16;

    // Request kinds carried in s_tuser
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;

    // Result kinds carried in m_tuser
    localparam logic [1:0] KIND_MISS    = 2'd0;
    localparam logic [1:0] KIND_PREFIX  = 2'd1;
    localparam logic [1:0] KIND_DEFAULT = 2'd2;

    // One trie entry as stored
    typedef struct packed {
        logic [7:0]  child;
        logic        valid;
        logic [31:0] hop;
    } entry_t;

    // One input beat after unpacking
    typedef struct packed {
        logic        req_type;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  node_slot;
        logic [7:0]  byte_slot;
        logic [7:0]  child_node;
        logic        prefix_valid;
        logic [31:0] entry_hop;
    } item_t;

    // Configuration registers as seen by the sequencer
    typedef struct packed {
        logic [7:0]  root_node;
        logic        default_enable;
        logic [31:0] default_hop;
    } cfg_t;

    // Single-port entry store command
    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [MEM_AW_MAX-1:0] addr;
        entry_t                wdata;
    } mem_cmd_t;

    // Finished lookup result
    typedef struct packed {
        logic        valid;
        logic [31:0] fwd_hop;
        logic [1:0]  kind;
    } res_t;

endpackage

// File: design/itl_entry_mem.sv
// Trie entry store: single-port memory with registered read data.
// Depends on itl_pkg for the entry and command types.
module itl_entry_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic              aclk,
    input  itl_pkg::mem_cmd_t cmd,
    output itl_pkg::entry_t   rdata
);
    import itl_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // One access per cycle: write or read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.addr[AW-1:0]] <= cmd.wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[cmd.addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/itl_walk_seq.sv
// Sequencer of the trie walk: clearing pass, entry writes, level-by-level lookup.
// Depends on itl_pkg; drives the single port of itl_entry_mem.
module itl_walk_seq #(
    parameter int NODE_COUNT = 256,
    parameter int NW         = 8,
    parameter int AW         = 16,
    parameter int DEPTH      = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  itl_pkg::item_t    item,
    input  itl_pkg::cfg_t     cfg,
    input  logic              out_free,
    output itl_pkg::res_t     res,
    output itl_pkg::mem_cmd_t cmd,
    input  itl_pkg::entry_t   rdata
);
    import itl_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [16:0]   NODE_LIM = 17'(NODE_COUNT);
    localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

    logic [1:0]         state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [7:0]         node_reg, node_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               pend_reg, pend_next;
    logic               found_reg, found_next;
    logic [31:0]        best_reg, best_next;

    logic        accept;
    logic [7:0]  cur_node;
    logic        cur_found;
    logic [31:0] cur_best;
    logic        node_ok;
    logic        wr_ok;
    logic        stop;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Entry returned by the last read folds into the walk this cycle
    assign cur_node  = pend_reg ? rdata.child : node_reg;
    assign cur_found = found_reg || (pend_reg && rdata.valid);
    assign cur_best  = (pend_reg && rdata.valid) ? rdata.hop : best_reg;
    assign node_ok   = (cur_node != 8'd0) && ({9'd0, cur_node} < NODE_LIM);
    assign stop      = !node_ok || (depth_reg == DEPTH_W'(ADDR_BYTES));
    assign wr_ok     = {9'd0, item.node_slot} < NODE_LIM;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        addr_next  = addr_reg;
        node_next  = node_reg;
        depth_next = depth_reg;
        pend_next  = 1'b0;
        found_next = found_reg;
        best_next  = best_reg;
        cmd        = '0;
        res        = '0;

        unique case (state_reg)
            // Zero every entry after reset, one per cycle
            ST_CLEAR: begin
                cmd.wr_en = 1'b1;
                cmd.addr  = MEM_AW_MAX'(clr_reg);
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            // Writes complete on the accept beat; lookups start the walk
            ST_IDLE: begin
                if (accept) begin
                    if (item.req_type == REQ_WRITE) begin
                        cmd.wr_en       = wr_ok;
                        cmd.addr        = MEM_AW_MAX'({item.node_slot[NW-1:0],
                                                       item.byte_slot});
                        cmd.wdata.child = item.child_node;
                        cmd.wdata.valid = item.prefix_valid;
                        cmd.wdata.hop   = item.entry_hop;
                    end else begin
                        addr_next  = {item.addr_high, item.addr_low};
                        node_next  = cfg.root_node;
                        depth_next = '0;
                        found_next = 1'b0;
                        best_next  = '0;
                        state_next = ST_LOOK;
                    end
                end
            end
            // One level per cycle: consume last entry, issue next read
            ST_LOOK: begin
                found_next = cur_found;
                best_next  = cur_best;
                node_next  = cur_node;
                if (stop) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.addr   = MEM_AW_MAX'({cur_node[NW-1:0],
                                              addr_reg[ADDR_W-1 -: 8]});
                    addr_next  = {addr_reg[ADDR_W-9:0], 8'd0};
                    depth_next = depth_reg + DEPTH_W'(1);
                    pend_next  = 1'b1;
                end
            end
            // Hand the result to the output register once it has room
            ST_DONE: begin
                if (out_free) begin
                    res.valid = 1'b1;
                    if (found_reg) begin
                        res.fwd_hop = best_reg;
                        res.kind    = KIND_PREFIX;
                    end else if (cfg.default_enable) begin
                        res.fwd_hop = cfg.default_hop;
                        res.kind    = KIND_DEFAULT;
                    end else begin
                        res.fwd_hop = '0;
                        res.kind    = KIND_MISS;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            depth_reg <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            depth_reg <= depth_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        node_reg <= node_next;
        best_reg <= best_next;
    end

    // Single port: never a read and a write together
    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr_en && cmd.rd_en))
        else $error("entry store read and write in one cycle");

    // Walk never goes past the last address byte
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(ADDR_BYTES))
        else $error("walk depth beyond address length");

    // A read is always followed by the walk consuming its data
    a_read_used: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |=> (pend_reg && state_reg == ST_LOOK))
        else $error("read data not consumed by walk");

    // A prefix result requires a valid entry seen on the walk
    a_prefix_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && res.kind == KIND_PREFIX) |-> found_reg)
        else $error("prefix match reported without valid entry");

    // A lookup accept starts the walk on the next cycle
    a_look_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && item.req_type == REQ_LOOKUP) |=> (state_reg == ST_LOOK && !pend_reg))
        else $error("lookup accept did not start walk");

endmodule

// File: design/ipv6_multibit_trie_lookup.sv
// Lookup: the walk reads one trie level per step, folding in each returned entry,
// then waits for room in the output register behind m_tvalid; s_tready returns only
// when the walk is idle again. Writes complete on the accept beat and give no result.
// Reset (aresetn, synchronous): registers go to root 1, default off, and a clearing
// pass zeroes all min(NODE_COUNT,256)*256 entries; s_tready stays low meanwhile.
// The output register lets the next item in while a result waits.
module ipv6_multibit_trie_lookup #(
    parameter int NODE_COUNT = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    // APB configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    // Request stream
    input  logic          s_tvalid,
    output logic          s_tready,
    // [63:0] addr_high, [127:64] addr_low, [135:128] node_slot,
    // [143:136] byte_slot, [151:144] child_node, [152] prefix_valid,
    // [184:153] entry_hop, [191:185] zero
    input  logic [191:0]  s_tdata,
    input  logic          s_tuser,   // [0] req_type
    // Result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,   // [31:0] fwd_hop
    output logic [1:0]    m_tuser    // [1:0] match_kind
);
    import itl_pkg::*;

    localparam int NODE_EFF = (NODE_COUNT > 256) ? 256 : NODE_COUNT;
    localparam int NW       = $clog2(NODE_EFF);
    localparam int AW       = NW + 8;
    localparam int DEPTH    = NODE_EFF * 256;

    localparam logic [1:0] REG_ROOT   = 2'd0;
    localparam logic [1:0] REG_DEF_EN = 2'd1;
    localparam logic [1:0] REG_DEF_HOP = 2'd2;

    cfg_t     cfg_reg;
    item_t    item;
    res_t     res;
    mem_cmd_t cmd;
    entry_t   rdata;
    logic     cfg_wr;

    logic        m_valid_reg;
    logic [31:0] m_hop_reg;
    logic [1:0]  m_kind_reg;
    logic        out_free;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.root_node      <= 8'd1;
            cfg_reg.default_enable <= 1'b0;
            cfg_reg.default_hop    <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ROOT:    cfg_reg.root_node      <= pwdata[7:0];
                REG_DEF_EN:  cfg_reg.default_enable <= pwdata[0];
                REG_DEF_HOP: cfg_reg.default_hop    <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROOT:    prdata = {24'd0, cfg_reg.root_node};
            REG_DEF_EN:  prdata = {31'd0, cfg_reg.default_enable};
            REG_DEF_HOP: prdata = cfg_reg.default_hop;
            default:     prdata = '0;
        endcase
    end

    // Unpack request beat
    assign item.req_type     = s_tuser;
    assign item.addr_high    = s_tdata[63:0];
    assign item.addr_low     = s_tdata[127:64];
    assign item.node_slot    = s_tdata[135:128];
    assign item.byte_slot    = s_tdata[143:136];
    assign item.child_node   = s_tdata[151:144];
    assign item.prefix_valid = s_tdata[152];
    assign item.entry_hop    = s_tdata[184:153];

    itl_walk_seq #(
        .NODE_COUNT (NODE_COUNT),
        .NW         (NW),
        .AW         (AW),
        .DEPTH      (DEPTH)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .item     (item),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .res      (res),
        .cmd      (cmd),
        .rdata    (rdata)
    );

    itl_entry_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .cmd   (cmd),
        .rdata (rdata)
    );

    // Output register
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_hop_reg  <= res.fwd_hop;
            m_kind_reg <= res.kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_hop_reg;
    assign m_tuser  = m_kind_reg;

endmodule

// File: tb/ipv6_multibit_trie_lookup_tb.sv
// Self-checking bench for ipv6_multibit_trie_lookup: builds trie routes, runs lookups
// under several register settings and compares every result with a shadow trie walk.
// Depends on itl_pkg and the ipv6_multibit_trie_lookup RTL.
`timescale 1ns / 100ps

module ipv6_multibit_trie_lookup_tb;
    import itl_pkg::*;

    localparam int NODE_COUNT = 256;

    // Register byte addresses on the APB port
    localparam logic [3:0] REG_ROOT_NODE   = 4'h0;
    localparam logic [3:0] REG_DEFAULT_EN  = 4'h4;
    localparam logic [3:0] REG_DEFAULT_HOP = 4'h8;

    typedef struct packed {
        logic [31:0] hop;
        logic [1:0]  kind;
    } route_res_t;

    // Shadow trie plus the queue of lookup answers still owed by the block
    class route_scoreboard;
        entry_t      trie_mem [];
        logic [7:0]  root_node;
        logic        default_enable;
        logic [31:0] default_hop;
        route_res_t  pending_routes [$];
        int          mismatches;

        function new();
            trie_mem = new[NODE_COUNT * 256];
            foreach (trie_mem[i]) trie_mem[i] = '0;
            root_node      = 8'd1;
            default_enable = 1'b0;
            default_hop    = 32'd0;
            mismatches     = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, msg);
        endfunction

        function void set_reg(logic [3:0] addr, logic [31:0] val);
            case (addr)
                REG_ROOT_NODE:   root_node = val[7:0];
                REG_DEFAULT_EN:  default_enable = val[0];
                REG_DEFAULT_HOP: default_hop = val;
                default: ;
            endcase
        endfunction

        // Longest-prefix walk, one address byte per level
        function route_res_t walk_trie(logic [127:0] addr);
            logic [7:0]  node;
            logic        found;
            logic [31:0] best;
            entry_t      ent;
            route_res_t  res;
            node  = root_node;
            found = 1'b0;
            best  = 32'd0;
            for (int d = 0; d < ADDR_BYTES; d++) begin
                if (node == 8'd0 || int'(node) >= NODE_COUNT) break;
                ent = trie_mem[{node, addr[127 - 8 * d -: 8]}];
                if (ent.valid) begin
                    found = 1'b1;
                    best  = ent.hop;
                end
                node = ent.child;
            end
            if (found) begin
                res.hop  = best;
                res.kind = KIND_PREFIX;
            end else if (default_enable) begin
                res.hop  = default_hop;
                res.kind = KIND_DEFAULT;
            end else begin
                res.hop  = 32'd0;
                res.kind = KIND_MISS;
            end
            return res;
        endfunction

        function void note_request(item_t it);
            entry_t ent;
            if (it.req_type == REQ_WRITE) begin
                if (int'(it.node_slot) < NODE_COUNT) begin
                    ent.child = it.child_node;
                    ent.valid = it.prefix_valid;
                    ent.hop   = it.entry_hop;
                    trie_mem[{it.node_slot, it.byte_slot}] = ent;
                end
            end else begin
                pending_routes.push_back(walk_trie({it.addr_high, it.addr_low}));
            end
        endfunction

        function void check_result(logic [31:0] hop, logic [1:0] kind);
            route_res_t want;
            if (pending_routes.size() == 0) begin
                flag($sformatf("unexpected result hop %h kind %0d", hop, kind));
                return;
            end
            want = pending_routes.pop_front();
            if (hop !== want.hop)
                flag($sformatf("fwd_hop expected %h actual %h", want.hop, hop));
            if (kind !== want.kind)
                flag($sformatf("match_kind expected %0d actual %0d", want.kind, kind));
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [3:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [191:0]  s_tdata = '0;
    logic          s_tuser = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [31:0]   m_tdata;
    logic [1:0]    m_tuser;

    route_scoreboard sb;
    logic [127:0]    route_addrs [$];
    logic [7:0]      root_cfg = 8'd1;
    logic            calm = 1'b0;

    ipv6_multibit_trie_lookup #(.NODE_COUNT(NODE_COUNT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #2 aclk = ~aclk;

    // Result side: check each accepted beat, stall about 7% of cycles outside calm phases
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        m_tready <= calm || ($urandom_range(0, 99) >= 7);
    end

    // Write one register, then read it back
    task automatic reg_write(input logic [3:0] addr, input logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(addr, val);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (addr)
            REG_ROOT_NODE:  want = {24'd0, val[7:0]};
            REG_DEFAULT_EN: want = {31'd0, val[0]};
            default:        want = val;
        endcase
        if (rd !== want)
            sb.flag($sformatf("register %h readback expected %h actual %h", addr, want, rd));
    endtask

    task automatic set_config(input logic [7:0] root, input logic en, input logic [31:0] hop);
        reg_write(REG_ROOT_NODE, {24'd0, root});
        reg_write(REG_DEFAULT_EN, {31'd0, en});
        reg_write(REG_DEFAULT_HOP, hop);
        root_cfg = root;
    endtask

    // Hold off until every lookup answer is in, then let in-flight writes settle
    task automatic wait_idle();
        while (sb.pending_routes.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    function automatic item_t random_item();
        item_t it;
        it.req_type     = REQ_LOOKUP;
        it.addr_high    = {$urandom, $urandom};
        it.addr_low     = {$urandom, $urandom};
        it.node_slot    = 8'($urandom);
        it.byte_slot    = 8'($urandom);
        it.child_node   = 8'($urandom);
        it.prefix_valid = 1'($urandom);
        it.entry_hop    = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] random_hop();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Drive one input beat and wait for it to be taken
    task automatic send_item(input item_t it);
        if (!calm && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it.entry_hop, it.prefix_valid, it.child_node, it.byte_slot,
                     it.node_slot, it.addr_low, it.addr_high};
        s_tuser  <= it.req_type;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(it);
    endtask

    task automatic send_lookup(input logic [127:0] addr);
        item_t it;
        it = random_item();
        it.addr_high = addr[127:64];
        it.addr_low  = addr[63:0];
        send_item(it);
    endtask

    task automatic send_entry(input logic [7:0] node, input logic [7:0] slot,
                              input logic [7:0] child, input logic valid,
                              input logic [31:0] hop);
        item_t it;
        it = random_item();
        it.req_type     = REQ_WRITE;
        it.node_slot    = node;
        it.byte_slot    = slot;
        it.child_node   = child;
        it.prefix_valid = valid;
        it.entry_hop    = hop;
        send_item(it);
    endtask

    // Lay one prefix path into the trie from the current root (node 1 when the root is zero)
    task automatic install_route(output int n_writes);
        logic [127:0] addr;
        logic [7:0]   node;
        logic [7:0]   child;
        logic         valid;
        int           len;
        addr = {$urandom, $urandom, $urandom, $urandom};
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        node = (root_cfg == 8'd0) ? 8'd1 : root_cfg;
        for (int d = 0; d < len; d++) begin
            if (d == len - 1)
                child = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
            else
                child = 8'($urandom_range(1, 255));
            valid = (d == len - 1) ? 1'b1 : ($urandom_range(0, 2) == 0);
            send_entry(node, addr[127 - 8 * d -: 8], child, valid, random_hop());
            node = child;
        end
        if (route_addrs.size() >= 64) route_addrs.delete($urandom_range(0, 63));
        route_addrs.push_back(addr);
        n_writes = len;
    endtask

    // Random traffic: mostly lookups along known routes, some noise
    task automatic run_phase(input int n_items, input logic quiet);
        int           sent;
        int           pick;
        int           nw;
        int           k;
        logic [127:0] addr;
        calm <= quiet;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 15 || route_addrs.size() == 0) begin
                install_route(nw);
                sent += nw;
            end else if (pick < 85) begin
                addr = route_addrs[$urandom_range(0, route_addrs.size() - 1)];
                if ($urandom_range(0, 1)) begin
                    k = $urandom_range(0, 15);
                    addr[127 - 8 * k -: 8] = 8'($urandom);
                end
                send_lookup(addr);
                sent++;
            end else if (pick < 95) begin
                send_lookup({$urandom, $urandom, $urandom, $urandom});
                sent++;
            end else begin
                send_entry(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                           $urandom);
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;
    endtask

    initial begin
        logic [127:0] chain_addr;
        logic [127:0] bent_addr;
        sb = new();
        chain_addr = 128'h2001_0db8_85a3_0000_0000_8a2e_0370_7334;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty store, full sixteen-level chain, node zero, hop extremes
        set_config(8'd1, 1'b0, 32'd0);
        send_lookup('0);
        send_lookup('1);
        for (int d = 0; d < ADDR_BYTES; d++)
            send_entry(8'(d + 1), chain_addr[127 - 8 * d -: 8],
                       (d == ADDR_BYTES - 1) ? 8'd200 : 8'(d + 2),
                       (d == 0 || d == ADDR_BYTES - 1),
                       (d == 0) ? 32'hFFFF_FFFF : 32'd0);
        send_entry(8'd0, chain_addr[127:120], 8'd3, 1'b1, 32'h1234_5678);
        send_lookup(chain_addr);
        bent_addr = chain_addr;
        bent_addr[127 - 8 * 5 -: 8] = ~bent_addr[127 - 8 * 5 -: 8];
        send_lookup(bent_addr);
        s_tvalid <= 1'b0;
        route_addrs.push_back(chain_addr);
        wait_idle();

        // Root node zero with default route: lookups stop at the root
        set_config(8'd0, 1'b1, 32'hFFFF_FFFF);
        run_phase(150, 1'b0);
        wait_idle();

        set_config(8'd1, 1'b1, $urandom);
        run_phase(300, 1'b1);
        wait_idle();

        set_config(8'd255, 1'b0, $urandom);
        run_phase(300, 1'b0);
        wait_idle();

        set_config(8'($urandom_range(1, 255)), 1'b1, 32'd0);
        run_phase(300, 1'b0);
        wait_idle();

        set_config(8'd1, 1'b0, 32'hFFFF_FFFF);
        run_phase(300, 1'b0);
        wait_idle();

        set_config(8'd1, 1'b1, $urandom);
        run_phase(400, 1'b0);
        wait_idle();

        if (sb.mismatches == 0 && sb.pending_routes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
